[src/tach_pkg.sv]
// Shared constants and types of the multi-channel tachometer.
package tach_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_W     = $clog2(CHANNELS);
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RPM_W    = 14;
  localparam int unsigned NF_W     = 16;
  localparam int unsigned STALE_W  = 16;

  // RPM is the dividend over the period; periods at or below SatPeriod
  // give a quotient above RpmMax and saturate.
  localparam int unsigned RpmDividend = 60000000;
  localparam int unsigned RpmMax      = 9999;
  localparam int unsigned SatPeriod   = RpmDividend / (RpmMax + 1);
  localparam int unsigned DVD_W       = $clog2(RpmDividend + 1);
  localparam int unsigned UsPerMs     = 1000;
  localparam int unsigned LIMIT_W     = $clog2(((1 << STALE_W) - 1) * UsPerMs + 1);

  typedef enum logic [1:0] {
    CFG_SENSOR_MASK = 2'd0,
    CFG_NOISE_US    = 2'd1,
    CFG_STALE_MS    = 2'd2
  } cfg_idx_e;

endpackage

[src/tach_div.sv]
// Bit-serial restoring divider: constant RPM dividend over a 32-bit period.
module tach_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tach_pkg::TIME_W-1:0]      divisor_i,
  output logic                             done_o,
  output logic [tach_pkg::RPM_W-1:0]       quot_o
);

  localparam int unsigned CntW = $clog2(tach_pkg::DVD_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CntW-1:0]               cnt_q;
  logic [tach_pkg::DVD_W-1:0]    dvd_q;
  logic [tach_pkg::DVD_W-1:0]    rem_q;
  logic [tach_pkg::RPM_W-1:0]    quo_q;
  logic [tach_pkg::TIME_W-1:0]   dvs_q;

  logic [tach_pkg::DVD_W:0]      rem_sh;
  logic [tach_pkg::TIME_W-1:0]   rem_ext;
  logic [tach_pkg::TIME_W-1:0]   rem_sub;
  logic                          fits;

  // Bring down one dividend bit, subtract when the divisor fits.
  assign rem_sh  = {rem_q, dvd_q[tach_pkg::DVD_W-1]};
  assign rem_ext = tach_pkg::TIME_W'(rem_sh);
  assign fits    = rem_ext >= dvs_q;
  assign rem_sub = rem_ext - dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(tach_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= tach_pkg::DVD_W'(tach_pkg::RpmDividend);
      rem_q <= '0;
      quo_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tach_pkg::DVD_W-2:0], 1'b0};
      rem_q <= fits ? rem_sub[tach_pkg::DVD_W-1:0] : rem_sh[tach_pkg::DVD_W-1:0];
      quo_q <= {quo_q[tach_pkg::RPM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[src/multi_channel_tachometer.sv]
// Top level of the multi-channel polled tachometer with RPM readout.
//
//   port group   dir  payload (lowest bit first)                         handshake
//   s_axis       in   now_us[31:0] tach_levels[35:32] clear_latch[39:36] tvalid/tready
//                     query_channel[41:40], zero pad to 48
//   m_axis       out  speed_rpm[13:0] pulse_total[45:14]                 tvalid/tready
//                     latch_flags[49:46], zero pad to 56
//   cfg          in   cfg_index (0 mask, 1 noise us, 2 stale ms), data   valid/ready
//
// A poll updates all channel state in its accept cycle, then goes through
// the staleness and saturation checks in the check state. When the speed
// needs a quotient, the bit-serial divider brings down the dividend bit by
// bit and then hands the quotient over; zero or saturated speeds go straight
// to the done state. Reset returns the registers to mask 15, noise 1000 us
// and timeout 2000 ms and clears every channel. A result waits in the output
// register while the next poll is taken; a finished poll holds until the
// output register is free.
module multi_channel_tachometer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // now_us, tach_levels, clear_latch, query_channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // speed_rpm, pulse_total, latch_flags
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned N = tach_pkg::CHANNELS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_e;

  // Poll fields.
  logic [tach_pkg::TIME_W-1:0] in_now;
  logic [N-1:0]                in_levels;
  logic [N-1:0]                in_clear;
  logic [1:0]                  in_query;
  logic                        in_fire;

  assign in_now    = s_axis_tdata_i[31:0];
  assign in_levels = s_axis_tdata_i[35:32];
  assign in_clear  = s_axis_tdata_i[39:36];
  assign in_query  = s_axis_tdata_i[41:40];

  // Configuration registers; the timeout is kept prescaled to microseconds.
  logic [N-1:0]                   mask_q;
  logic [tach_pkg::NF_W-1:0]      noise_q;
  logic [tach_pkg::STALE_W-1:0]   stale_q;
  logic [tach_pkg::LIMIT_W-1:0]   limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= N'(15);
      noise_q <= tach_pkg::NF_W'(1000);
      stale_q <= tach_pkg::STALE_W'(2000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tach_pkg::CFG_SENSOR_MASK: mask_q  <= cfg_data_i[N-1:0];
        tach_pkg::CFG_NOISE_US:    noise_q <= cfg_data_i;
        tach_pkg::CFG_STALE_MS:    stale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= tach_pkg::LIMIT_W'(stale_q) * tach_pkg::LIMIT_W'(tach_pkg::UsPerMs);
  end

  // Per-channel state.
  logic [N-1:0]                prev_q, known_q, seen_q, latch_q;
  logic [N-1:0]                prev_d, known_d, seen_d, latch_d;
  logic [tach_pkg::TIME_W-1:0] count_q  [N];
  logic [tach_pkg::TIME_W-1:0] lft_q    [N];
  logic [tach_pkg::TIME_W-1:0] period_q [N];
  logic [tach_pkg::TIME_W-1:0] count_d  [N];
  logic [tach_pkg::TIME_W-1:0] lft_d    [N];
  logic [tach_pkg::TIME_W-1:0] period_d [N];
  logic [tach_pkg::TIME_W-1:0] gap      [N];

  // Clear the latch first, then learn the level or look for a falling edge.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      prev_d[i]   = prev_q[i];
      known_d[i]  = known_q[i];
      seen_d[i]   = seen_q[i];
      latch_d[i]  = latch_q[i] & ~in_clear[i];
      count_d[i]  = count_q[i];
      lft_d[i]    = lft_q[i];
      period_d[i] = period_q[i];
      gap[i]      = in_now - lft_q[i];
      if (mask_q[i]) begin
        prev_d[i] = in_levels[i];
        if (!known_q[i]) begin
          known_d[i] = 1'b1;
        end else if (prev_q[i] && !in_levels[i]) begin
          count_d[i] = count_q[i] + tach_pkg::TIME_W'(1);
          if (seen_q[i] && gap[i] >= tach_pkg::TIME_W'(noise_q)) begin
            period_d[i] = gap[i];
          end
          lft_d[i]   = in_now;
          seen_d[i]  = 1'b1;
          latch_d[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      known_q <= '0;
      seen_q  <= '0;
      latch_q <= '0;
      for (int i = 0; i < N; i++) begin
        count_q[i]  <= '0;
        lft_q[i]    <= '0;
        period_q[i] <= '0;
      end
    end else if (in_fire) begin
      prev_q   <= prev_d;
      known_q  <= known_d;
      seen_q   <= seen_d;
      latch_q  <= latch_d;
      count_q  <= count_d;
      lft_q    <= lft_d;
      period_q <= period_d;
    end
  end

  // Query control.
  state_e                      state_q;
  logic [tach_pkg::TIME_W-1:0] now_q;
  logic [tach_pkg::CH_W-1:0]   qch_q;
  logic                        qok_q;
  logic [tach_pkg::RPM_W-1:0]  speed_q;
  logic                        out_valid_q;
  logic [tach_pkg::RPM_W-1:0]  out_speed_q;
  logic [tach_pkg::TIME_W-1:0] out_pulse_q;
  logic [N-1:0]                out_flags_q;

  logic [tach_pkg::TIME_W-1:0] q_period;
  logic [tach_pkg::TIME_W-1:0] q_age;
  logic                        q_zero;
  logic                        q_sat;
  logic                        div_start;
  logic                        div_done;
  logic [tach_pkg::RPM_W-1:0]  div_quot;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign q_period  = period_q[qch_q];
  assign q_age     = now_q - lft_q[qch_q];
  assign q_zero    = !qok_q || (q_period == '0) || (q_age > tach_pkg::TIME_W'(limit_q));
  assign q_sat     = q_period <= tach_pkg::TIME_W'(tach_pkg::SatPeriod);
  assign div_start = (state_q == S_CHECK) && !q_zero && !q_sat;

  tach_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (q_period),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // Load a finished poll into a free or draining output register.
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (q_zero) begin
            state_q <= S_DONE;
          end else if (q_sat) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is empty or being drained.
          if (!out_valid_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q <= in_now;
      qch_q <= in_query[tach_pkg::CH_W-1:0];
      qok_q <= 32'(in_query) < 32'(N);
    end
    if (state_q == S_CHECK) begin
      speed_q <= q_zero ? '0 : tach_pkg::RPM_W'(tach_pkg::RpmMax);
    end else if (state_q == S_DIV && div_done) begin
      speed_q <= div_quot;
    end
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready_i)) begin
      out_speed_q <= speed_q;
      out_pulse_q <= qok_q ? count_q[qch_q] : '0;
      out_flags_q <= latch_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_flags_q, out_pulse_q, out_speed_q};

  // Checks.
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_speed_q <= tach_pkg::RPM_W'(tach_pkg::RpmMax))
    else $error("speed above saturation");

  a_one_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("second poll taken while one is in work");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_sat_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && (q_zero || q_sat)) |=> state_q == S_DONE)
    else $error("zero or saturated speed went to the divider");

endmodule

[dv/testbench.sv]
// Self-checking testbench of the multi-channel tachometer: directed and random polls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Speed arithmetic of the tachometer.
  localparam int unsigned SpeedDividend = 60_000_000;
  localparam int unsigned SpeedCeiling  = 9999;
  localparam int unsigned UsPerMilli    = 1000;
  // Watchdog: cycles with no transaction on any channel before giving up.
  localparam int unsigned StallLimit    = 2000;
  // Settle beyond the slowest poll, from accept to result, before the final check.
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned MaxShown      = 10;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseItems    = 150;

  // One poll, packed the way s_axis_tdata carries it (now in the lowest bits).
  typedef struct packed {
    logic [1:0]  query;
    logic [3:0]  clear;
    logic [3:0]  levels;
    logic [31:0] now;
  } poll_t;

  // One reading, packed the way m_axis_tdata carries it below the pad bits.
  typedef struct packed {
    logic [3:0]  flags;
    logic [31:0] pulses;
    logic [13:0] speed;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;   // now_us, tach_levels, clear_latch, query_channel
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;   // speed_rpm, pulse_total, latch_flags
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  multi_channel_tachometer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the registers and of every channel.
  logic [3:0]                    mask_q;
  logic [15:0]                   noise_q;
  logic [15:0]                   stale_q;
  logic [tach_pkg::CHANNELS-1:0] lvl_prev;
  logic [tach_pkg::CHANNELS-1:0] lvl_known;
  logic [tach_pkg::CHANNELS-1:0] fall_valid;
  logic [tach_pkg::CHANNELS-1:0] edge_flag;
  logic [31:0]                   pulse_cnt [tach_pkg::CHANNELS];
  logic [31:0]                   fall_time [tach_pkg::CHANNELS];
  logic [31:0]                   period    [tach_pkg::CHANNELS];

  // Readings owed by the block, oldest first.
  reading_t    readings_due[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  // Running stimulus: poll timestamp and the tach waveform of every channel.
  logic [31:0] stim_now;
  logic [3:0]  stim_wave;

  // Put the shadow state in its reset condition.
  function automatic void tach_clear();
    mask_q     = 4'hF;
    noise_q    = 16'd1000;
    stale_q    = 16'd2000;
    lvl_prev   = '0;
    lvl_known  = '0;
    fall_valid = '0;
    edge_flag  = '0;
    for (int ch = 0; ch < tach_pkg::CHANNELS; ch++) begin
      pulse_cnt[ch] = '0;
      fall_time[ch] = '0;
      period[ch]    = '0;
    end
  endfunction

  // Apply one poll to the shadow state and return the reading it yields.
  function automatic reading_t tach_advance(poll_t p);
    reading_t    r;
    logic [31:0] span;
    logic [31:0] age;
    logic [31:0] limit;
    logic [31:0] quot;
    for (int ch = 0; ch < tach_pkg::CHANNELS; ch++) begin
      // Clear acts first and on every channel, fitted or not.
      if (p.clear[ch]) edge_flag[ch] = 1'b0;
      // Unfitted channels keep their whole state frozen.
      if (!mask_q[ch]) continue;
      // The first poll of a channel only learns its level.
      if (!lvl_known[ch]) begin
        lvl_known[ch] = 1'b1;
        lvl_prev[ch]  = p.levels[ch];
        continue;
      end
      if (lvl_prev[ch] && !p.levels[ch]) begin
        pulse_cnt[ch] = pulse_cnt[ch] + 1;
        // Measure only against an earlier edge; drop periods below the noise floor.
        if (fall_valid[ch]) begin
          span = p.now - fall_time[ch];
          if (span >= noise_q) period[ch] = span;
        end
        fall_time[ch]  = p.now;
        fall_valid[ch] = 1'b1;
        edge_flag[ch]  = 1'b1;
      end
      lvl_prev[ch] = p.levels[ch];
    end
    r       = '0;
    r.flags = edge_flag;
    if (p.query < tach_pkg::CHANNELS) begin
      r.pulses = pulse_cnt[p.query];
      // Age is taken after this poll's update, against this poll's timestamp.
      age   = p.now - fall_time[p.query];
      limit = stale_q * UsPerMilli;
      if (period[p.query] != 0 && age <= limit) begin
        quot    = SpeedDividend / period[p.query];
        r.speed = (quot > SpeedCeiling) ? 14'(SpeedCeiling) : quot[13:0];
      end
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxShown)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Clock: 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check each result transaction against the oldest owed reading, then
  // pick the sink's ready for the next cycle.
  always @(posedge clk_i) begin : result_check
    reading_t got;
    reading_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = reading_t'(m_axis_tdata_o[49:0]);
      if (readings_due.size() == 0) begin
        note_mismatch("unrequested result", 0, 1);
      end else begin
        want = readings_due.pop_front();
        if (got.speed != want.speed)   note_mismatch("speed_rpm", want.speed, got.speed);
        if (got.pulses != want.pulses) note_mismatch("pulse_total", want.pulses, got.pulses);
        if (got.flags != want.flags)   note_mismatch("latch_flags", want.flags, got.flags);
        if (m_axis_tdata_o[55:50] != '0)
          note_mismatch("tdata pad", 0, m_axis_tdata_o[55:50]);
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: abort when no transaction moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("FAIL multi_channel_tachometer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one poll: idle at random first, then hold it until accepted.
  // Leave tvalid high afterwards so back-to-back polls never drop it.
  task automatic send_poll(poll_t p);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, p};
    do @(posedge clk_i); while (!s_axis_tready_o);
    readings_due.push_back(tach_advance(p));
  endtask

  task automatic poll_at(logic [31:0] now, logic [3:0] levels, logic [3:0] clear,
                         logic [1:0] query);
    poll_t p;
    p.now    = now;
    p.levels = levels;
    p.clear  = clear;
    p.query  = query;
    stim_now  = now;
    stim_wave = levels;
    send_poll(p);
  endtask

  // Stop sending and wait until every owed reading has come back.
  task automatic wait_for_readings();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (readings_due.size() != 0);
  endtask

  task automatic write_reg(tach_pkg::cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      tach_pkg::CFG_SENSOR_MASK: mask_q  = value[3:0];
      tach_pkg::CFG_NOISE_US:    noise_q = value;
      tach_pkg::CFG_STALE_MS:    stale_q = value;
      default: ;
    endcase
    // Wait for another clock edge so the next write never raises valid in this step.
    @(posedge clk_i);
  endtask

  // Reprogram all registers, only once the block has gone idle.
  task automatic configure(logic [3:0] mask, logic [15:0] noise, logic [15:0] stale);
    wait_for_readings();
    write_reg(tach_pkg::CFG_SENSOR_MASK, {12'b0, mask});
    write_reg(tach_pkg::CFG_NOISE_US, noise);
    write_reg(tach_pkg::CFG_STALE_MS, stale);
  endtask

  // Next random poll: mostly a plausible waveform sampled at a random pace,
  // with some fully random polls mixed in as noise.
  function automatic poll_t next_poll();
    poll_t       p;
    int unsigned pick;
    if ($urandom_range(99) < 12) begin
      p.now    = $urandom;
      p.levels = 4'($urandom);
      p.clear  = 4'($urandom);
      p.query  = 2'($urandom);
      return p;
    end
    pick = $urandom_range(99);
    if (pick < 68)      stim_now += $urandom_range(4000, 150);
    else if (pick < 90) stim_now += $urandom_range(60000, 4000);
    else if (pick < 97) stim_now += $urandom_range(3_000_000, 60000);
    else                stim_now += $urandom;
    for (int ch = 0; ch < 4; ch++)
      if ($urandom_range(99) < 45) stim_wave[ch] = ~stim_wave[ch];
    p.now    = stim_now;
    p.levels = stim_wave;
    p.clear  = ($urandom_range(99) < 15) ? 4'($urandom) : 4'h0;
    p.query  = 2'($urandom_range(3));
    return p;
  endfunction

  // Learning poll, first edge, noise rejection, saturation, timestamp wrap,
  // staleness right at and just past the timeout, every query value.
  task automatic test_edge_basics();
    poll_at(32'h0000_0000, 4'hF, 4'h0, 2'd0);  // learn all levels
    poll_at(32'd100,       4'h0, 4'h0, 2'd0);  // first fall: counted, no period
    poll_at(32'd200,       4'hF, 4'h0, 2'd1);
    poll_at(32'd700,       4'h0, 4'h0, 2'd1);  // 600 us: below the noise floor
    poll_at(32'd800,       4'hF, 4'h0, 2'd2);
    poll_at(32'd1800,      4'h0, 4'h0, 2'd2);  // 1100 us: saturates
    poll_at(32'hFFFF_E000, 4'hF, 4'h0, 2'd3);
    poll_at(32'hFFFF_FFFF, 4'h0, 4'h0, 2'd3);  // huge period: quotient 0
    poll_at(32'h0000_1000, 4'hF, 4'h0, 2'd0);
    poll_at(32'h0000_2000, 4'h0, 4'h0, 2'd0);  // wraps: 8193 us
    poll_at(32'h0000_2000 + 32'd2_000_000, 4'hF, 4'h0, 2'd0);  // age at the limit
    poll_at(32'h0000_2000 + 32'd2_000_001, 4'hF, 4'h0, 2'd1);  // one past: stale
  endtask

  // Clear and edge in the same poll leave the latch set.
  task automatic test_latch_clear();
    poll_at(stim_now + 32'd1000, 4'h0, 4'hF, 2'd2);
    poll_at(stim_now + 32'd1000, 4'h0, 4'h5, 2'd3);
    poll_at(stim_now + 32'd1000, 4'hF, 4'hA, 2'd0);
  endtask

  // Unfitted channels freeze, still take clears, and resume when refitted.
  task automatic test_sensor_mask();
    configure(4'h5, 16'd1000, 16'd2000);
    poll_at(stim_now + 32'd7000, 4'h0, 4'h0, 2'd0);
    poll_at(stim_now + 32'd7000, 4'hF, 4'hF, 2'd1);
    configure(4'h0, 16'd1000, 16'd2000);
    poll_at(stim_now + 32'd7000, 4'h0, 4'h0, 2'd2);
    configure(4'hF, 16'd1000, 16'd2000);
    poll_at(stim_now + 32'd7000, 4'h0, 4'h0, 2'd3);
  endtask

  // Zero noise floor admits a zero period, which reads as no speed; zero
  // timeout still shows the speed on the edge poll; then the top extremes.
  task automatic test_noise_and_timeout();
    configure(4'hF, 16'd0, 16'd0);
    poll_at(stim_now + 32'd9000, 4'hF, 4'h0, 2'd0);
    poll_at(stim_now,            4'h0, 4'h0, 2'd0);
    poll_at(stim_now,            4'hF, 4'h0, 2'd1);
    poll_at(stim_now,            4'h0, 4'h0, 2'd1);
    configure(4'hF, 16'hFFFF, 16'hFFFF);
    poll_at(stim_now + 32'd70000, 4'hF, 4'h0, 2'd2);
    poll_at(stim_now + 32'd70000, 4'h0, 4'h0, 2'd2);
  endtask

  // Phases of random polls under different register settings.
  task automatic test_random_traffic();
    int unsigned count;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      count = PhaseItems;
      case (phase)
        0: configure(4'hF, 16'd1000, 16'd2000);
        1: configure(4'hF, 16'd0, 16'd0);
        2: configure(4'hF, 16'hFFFF, 16'hFFFF);
        3: begin
          // Nothing fitted: only clears and readback move; keep it short.
          configure(4'h0, 16'($urandom), 16'($urandom));
          count = 40;
        end
        4: configure(4'($urandom_range(15, 1)), 16'($urandom_range(3000)),
                     16'($urandom_range(3)));
        default: configure(4'($urandom), 16'($urandom_range(8000)), 16'($urandom));
      endcase
      // Drop all idling on both sides for one whole phase.
      src_idle_pct  = (phase == 4) ? 0 : 26;
      sink_idle_pct = (phase == 4) ? 0 : 26;
      for (int n = 0; n < count; n++) begin
        // Hold off once mid-phase until the block has drained completely.
        if (phase == 5 && n == count / 2) wait_for_readings();
        send_poll(next_poll());
      end
    end
    src_idle_pct  = 26;
    sink_idle_pct = 26;
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= tach_pkg::CFG_SENSOR_MASK;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 26;
    sink_idle_pct = 26;
    stim_now      = '0;
    stim_wave     = '0;
    tach_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_basics();
    test_latch_clear();
    test_sensor_mask();
    test_noise_and_timeout();
    test_random_traffic();

    // Drain, then let the slowest possible poll settle to catch strays.
    wait_for_readings();
    repeat (SettleCycles) @(posedge clk_i);
    if (readings_due.size() != 0) mismatches += readings_due.size();
    if (mismatches == 0) begin
      $display("PASS multi_channel_tachometer");
    end else begin
      $display("FAIL multi_channel_tachometer");
    end
    $finish;
  end

endmodule
